@@ rtl/hbse_pkg.sv @@
// ----------------------------------------------------------------------------
// hbse_pkg: shared definitions for the HDLC byte stuffing encoder
// Counter width, register indexes and reset values, the run descriptor that
// travels from the front stage to the back stage, and small helpers.
// ----------------------------------------------------------------------------
package hbse_pkg;

  // Width of the per-frame output byte counter
  localparam int COUNT_BITS = 8;
  localparam int CMP_W      = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Results one request can produce, and the slot index width
  localparam int MAX_RES = 4;
  localparam int SLOT_W  = $clog2(MAX_RES);
  localparam int LEN_W   = $clog2(MAX_RES + 1);

  // Escape transform
  localparam logic [7:0] XOR_MASK = 8'h20;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_START_FLAG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_FLAG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = 2'd3;

  // Configuration reset values
  localparam logic [7:0] START_FLAG_RST = 8'd126;
  localparam logic [7:0] STOP_FLAG_RST  = 8'd126;
  localparam logic [7:0] ESCAPE_RST     = 8'd125;
  localparam logic [7:0] MAX_LEN_RST    = 8'd255;

  // All results of one request, resolved by the front stage
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [MAX_RES-1:0]      err;
    logic [LEN_W-1:0]        len;
  } run_t;

  // Queue status toward the back stage and the intake stall
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Saturating counter increment
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  // True while the frame still has room for one more byte
  function automatic logic room_left(input logic [COUNT_BITS-1:0] c,
                                     input logic [7:0] max_len);
    room_left = CMP_W'(c) < CMP_W'(max_len);
  endfunction

endpackage

@@ rtl/hbse_front.sv @@
// ----------------------------------------------------------------------------
// hbse_front: request intake and classification
// Holds configuration and frame state, resolves every result of a request
// combinationally and hands the finished run to the queue.
// ----------------------------------------------------------------------------
module hbse_front import hbse_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 accept_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 byte_present_i,
  input  logic                 opens_frame_i,
  input  logic                 closes_frame_i,
  output logic                 push_o,
  output run_t                 run_o
);

  logic [7:0] start_q, stop_q, esc_q, max_len_q;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic drop_q, drop_d;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= START_FLAG_RST;
      stop_q    <= STOP_FLAG_RST;
      esc_q     <= ESCAPE_RST;
      max_len_q <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_FLAG: start_q   <= cfg_data_i;
        REG_STOP_FLAG:  stop_q    <= cfg_data_i;
        REG_ESCAPE:     esc_q     <= cfg_data_i;
        REG_MAX_LEN:    max_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Resolve the run of the current request
  always_comb begin
    logic [COUNT_BITS-1:0] c;
    logic [LEN_W-1:0]      n;
    logic                  ovf;
    logic [7:0]            data;
    c      = opens_frame_i ? '0 : cnt_q;
    n      = '0;
    ovf    = 1'b0;
    data   = in_byte_i;
    run_o  = '0;
    cnt_d  = cnt_q;
    drop_d = drop_q;
    push_o = 1'b0;

    if (!opens_frame_i && drop_q) begin
      // dropping: nothing sent, a close ends the drop
      if (closes_frame_i) begin
        drop_d = 1'b0;
        cnt_d  = '0;
      end
    end else begin
      // start flag
      if (opens_frame_i) begin
        if (max_len_q < 8'd2) begin
          ovf = 1'b1;
        end else begin
          run_o.bytes[n[SLOT_W-1:0]] = start_q;
          n = n + 1'b1;
          c = sat_inc(c);
        end
      end
      // data byte, escaped when it matches a control value
      if (!ovf && byte_present_i) begin
        if (!room_left(c, max_len_q)) begin
          ovf = 1'b1;
        end else begin
          if (data == esc_q || data == start_q || data == stop_q) begin
            run_o.bytes[n[SLOT_W-1:0]] = esc_q;
            n    = n + 1'b1;
            c    = sat_inc(c);
            data = data ^ XOR_MASK;
          end
          if (!room_left(c, max_len_q)) begin
            ovf = 1'b1;
          end else begin
            run_o.bytes[n[SLOT_W-1:0]] = data;
            n = n + 1'b1;
            c = sat_inc(c);
          end
        end
      end
      // stop flag
      if (!ovf && closes_frame_i) begin
        if (!room_left(c, max_len_q)) begin
          ovf = 1'b1;
        end else begin
          run_o.bytes[n[SLOT_W-1:0]] = stop_q;
          n = n + 1'b1;
          c = sat_inc(c);
        end
      end
      // overflow result ends the run
      if (ovf) begin
        run_o.bytes[n[SLOT_W-1:0]] = 8'd0;
        run_o.err[n[SLOT_W-1:0]]   = 1'b1;
        n = n + 1'b1;
      end
      cnt_d     = closes_frame_i ? '0 : c;
      drop_d    = ovf && !closes_frame_i;
      run_o.len = n;
      push_o    = accept_i && (n != '0);
    end
  end

  // Frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else if (accept_i) begin
      cnt_q  <= cnt_d;
      drop_q <= drop_d;
    end
  end

endmodule

@@ rtl/hbse_queue.sv @@
// ----------------------------------------------------------------------------
// hbse_queue: two-entry run queue
// Decouples the front stage from the output serializer.
// ----------------------------------------------------------------------------
module hbse_queue import hbse_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  run_t    push_data_i,
  input  logic    pop_i,
  output run_t    head_o,
  output q_stat_t stat_o
);

  run_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/hbse_back.sv @@
// ----------------------------------------------------------------------------
// hbse_back: output serializer
// Walks the slots of the head run, one result per cycle while the output is
// not stalled, into the output register.
// ----------------------------------------------------------------------------
module hbse_back import hbse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  run_t       head_i,
  input  q_stat_t    q_stat_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       overflow_error_o,
  output logic       last_of_run_o
);

  logic [SLOT_W-1:0] idx_q, idx_d;
  logic              valid_q;
  logic              load, last;

  // Load a new result when the output register is free or being taken
  assign load  = !q_stat_i.empty && (!valid_q || !out_stall_i);
  assign last  = (LEN_W'(idx_q) + 1'b1) == head_i.len;
  assign pop_o = load && last;
  assign idx_d = last ? '0 : idx_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= idx_d;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_o       <= head_i.bytes[idx_q];
      overflow_error_o <= head_i.err[idx_q];
      last_of_run_o    <= last;
    end
  end

  assign out_valid_o = valid_q;

endmodule

@@ rtl/hdlc_byte_stuff_encoder_top.sv @@
// ----------------------------------------------------------------------------
// hdlc_byte_stuff_encoder_top: HDLC-style framing encoder
// Path: a request's run is written into the run queue, and its results then
// pass through the output register. Throughput: one request per cycle is
// taken while the two-entry run queue has room; the output gives one result
// per cycle while not stalled, and a request makes zero to four results.
// Reset: async active low; config returns to defaults, frame count, drop
// state, queue fill level and output valid are cleared.
// ----------------------------------------------------------------------------
module hdlc_byte_stuff_encoder_top import hbse_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 byte_present_i,
  input  logic                 opens_frame_i,
  input  logic                 closes_frame_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic                 overflow_error_o,
  output logic                 last_of_run_o
);

  logic    accept, push, pop;
  run_t    run, head;
  q_stat_t q_stat;

  // Stall intake only while the queue is full
  assign in_stall_o = q_stat.full;
  assign accept     = in_valid_i && !q_stat.full;

  hbse_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .accept_i (accept),
    .in_byte_i,
    .byte_present_i,
    .opens_frame_i,
    .closes_frame_i,
    .push_o   (push),
    .run_o    (run)
  );

  hbse_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (run),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  hbse_back u_back (
    .clk_i,
    .rst_ni,
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_valid_o,
    .out_stall_i,
    .out_byte_o,
    .overflow_error_o,
    .last_of_run_o
  );

endmodule

@@ rtl/hbse_checker.sv @@
// ----------------------------------------------------------------------------
// hbse_checker: port-level checks for the HDLC byte stuffing encoder
// Watches the top level ports only; attached by bind.
// ----------------------------------------------------------------------------
module hbse_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       overflow_error_o,
  input logic       last_of_run_o
);

  // Overflow result carries a zero byte and ends its run
  a_ovf_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_error_o |-> out_byte_o == 8'd0 && last_of_run_o)
    else $error("overflow result malformed");

  // A run that is not finished continues in the next cycle
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o)
    else $error("gap inside a run");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
      $stable(overflow_error_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // An overflow result is never followed inside the same run
  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> !overflow_error_o)
    else $error("overflow result not last");

endmodule

bind hdlc_byte_stuff_encoder_top hbse_checker u_hbse_checker (.*);

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hdlc_byte_stuff_encoder_top
// Sends framed byte requests through the valid/stall input, predicts the line
// bytes (flags, escapes, overflow marker) with a behavioral model of the
// framer, and checks every output result in order. It covers directed corner
// cases, then random frames over several register settings and pacing modes.
// ----------------------------------------------------------------------------
module testbench;
  import hbse_pkg::*;

  localparam int IDLE_LIMIT      = 2000;
  localparam int ITEMS_PER_PHASE = 52;
  localparam int SETTLE_CYCLES   = 6;

  // One expected line result
  typedef struct {
    logic [7:0] octet;
    logic       err;
    logic       last;
  } line_rec_t;

  typedef enum int {
    PACE_FULL,
    PACE_SENDER_GAPS,
    PACE_RECEIVER_STALLS,
    PACE_BOTH
  } pace_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [7:0]           cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           in_byte_i;
  logic                 byte_present_i;
  logic                 opens_frame_i;
  logic                 closes_frame_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [7:0]           out_byte_o;
  logic                 overflow_error_o;
  logic                 last_of_run_o;

  // Mirror of the framer registers and state
  logic [7:0]            cfg_start = START_FLAG_RST;
  logic [7:0]            cfg_stop  = STOP_FLAG_RST;
  logic [7:0]            cfg_esc   = ESCAPE_RST;
  logic [7:0]            cfg_max   = MAX_LEN_RST;
  logic [COUNT_BITS-1:0] frame_len = '0;
  logic                  dropping  = 1'b0;

  line_rec_t line_q[$];
  int        mismatch_count = 0;
  int        gap_pct        = 0;
  int        stall_pct      = 0;

  hdlc_byte_stuff_encoder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .byte_present_i  (byte_present_i),
    .opens_frame_i   (opens_frame_i),
    .closes_frame_i  (closes_frame_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .overflow_error_o(overflow_error_o),
    .last_of_run_o   (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Frame byte counter, saturating
  function automatic void count_frame_byte();
    if (frame_len != CNT_MAX) frame_len++;
  endfunction

  // Work out the line results of one accepted request
  function automatic void predict_line_bytes(input logic [7:0] data_in, input logic present,
                                             input logic opens, input logic closes);
    line_rec_t  runs[4];
    int         n;
    logic       ovf;
    logic [7:0] d;
    n   = 0;
    ovf = 1'b0;
    d   = data_in;
    if (opens) begin
      frame_len = '0;
      dropping  = 1'b0;
      if (cfg_max < 2) begin
        ovf = 1'b1;
      end else begin
        runs[n] = '{cfg_start, 1'b0, 1'b0};
        n++;
        count_frame_byte();
      end
    end else if (dropping) begin
      // rest of frame discarded; a close ends the drop
      if (closes) begin
        dropping  = 1'b0;
        frame_len = '0;
      end
      return;
    end
    if (!ovf && present) begin
      if (frame_len >= cfg_max) begin
        ovf = 1'b1;
      end else begin
        if (d == cfg_esc || d == cfg_start || d == cfg_stop) begin
          runs[n] = '{cfg_esc, 1'b0, 1'b0};
          n++;
          count_frame_byte();
          d = d ^ XOR_MASK;
        end
        if (frame_len >= cfg_max) begin
          ovf = 1'b1;
        end else begin
          runs[n] = '{d, 1'b0, 1'b0};
          n++;
          count_frame_byte();
        end
      end
    end
    if (!ovf && closes) begin
      if (frame_len >= cfg_max) begin
        ovf = 1'b1;
      end else begin
        runs[n] = '{cfg_stop, 1'b0, 1'b0};
        n++;
        count_frame_byte();
      end
    end
    if (ovf) begin
      runs[n] = '{8'h00, 1'b1, 1'b0};
      n++;
      if (closes) begin
        dropping  = 1'b0;
        frame_len = '0;
      end else begin
        dropping = 1'b1;
      end
    end else if (closes) begin
      frame_len = '0;
    end
    if (n > 0) runs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) line_q.push_back(runs[i]);
  endfunction

  // Predict on every accepted request
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      predict_line_bytes(in_byte_i, byte_present_i, opens_frame_i, closes_frame_i);
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin : check_results
    line_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (line_q.size() == 0) begin
        $error("unexpected result: out_byte 0x%02h overflow_error %0b last_of_run %0b",
               out_byte_o, overflow_error_o, last_of_run_o);
        mismatch_count++;
      end else begin
        want = line_q.pop_front();
        if (out_byte_o !== want.octet) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", want.octet, out_byte_o);
          mismatch_count++;
        end
        if (overflow_error_o !== want.err) begin
          $error("overflow_error: expected %0b, got %0b", want.err, overflow_error_o);
          mismatch_count++;
        end
        if (last_of_run_o !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, last_of_run_o);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver back-pressure
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Ends the run when no request or result moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic set_pace(input pace_e pace);
    case (pace)
      PACE_FULL: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      PACE_SENDER_GAPS: begin
        gap_pct   = 56;
        stall_pct = 0;
      end
      PACE_RECEIVER_STALLS: begin
        gap_pct   = 0;
        stall_pct = 56;
      end
      default: begin
        gap_pct   = 12;
        stall_pct = 12;
      end
    endcase
  endtask

  // Drive one request and hold it until accepted
  task automatic send_request(input logic [7:0] data, input logic present,
                              input logic opens, input logic closes);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_byte_i      = data;
    byte_present_i = present;
    opens_frame_i  = opens;
    closes_frame_i = closes;
    in_valid_i     = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait for every expected result plus a settle time
  task automatic wait_line_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (line_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    case (idx)
      REG_START_FLAG: cfg_start = value;
      REG_STOP_FLAG:  cfg_stop  = value;
      REG_ESCAPE:     cfg_esc   = value;
      default:        cfg_max   = value;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_all_regs(input logic [7:0] start, input logic [7:0] stop,
                              input logic [7:0] esc, input logic [7:0] max_len);
    write_reg(REG_START_FLAG, start);
    write_reg(REG_STOP_FLAG, stop);
    write_reg(REG_ESCAPE, esc);
    write_reg(REG_MAX_LEN, max_len);
  endtask

  // Bias data toward the control values
  function automatic logic [7:0] pick_line_byte();
    case ($urandom_range(0, 9))
      0: return cfg_start;
      1: return cfg_stop;
      2: return cfg_esc;
      3: return cfg_esc ^ XOR_MASK;
      default: return 8'($urandom);
    endcase
  endfunction

  // One frame with random content; optionally left unclosed
  task automatic send_random_frame(output int sent, input logic leave_open);
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
    for (int i = 0; i < len; i++)
      send_request(pick_line_byte(), $urandom_range(0, 4) != 0, i == 0,
                   (i == len - 1) && !leave_open);
    sent = len;
  endtask

  // Flags, escaping and items outside a frame at reset settings
  task automatic test_basic_framing();
    set_pace(PACE_FULL);
    send_request(8'h41, 1'b1, 1'b1, 1'b1);
    send_request(8'h7e, 1'b1, 1'b1, 1'b0);
    send_request(8'h7d, 1'b1, 1'b0, 1'b0);
    send_request(8'hff, 1'b1, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b0, 1'b1);
    // nothing to send
    send_request(8'ha5, 1'b0, 1'b0, 1'b0);
    // outside a frame, then a bare close
    send_request(8'h55, 1'b1, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b0, 1'b1);
    send_request(8'h00, 1'b0, 1'b1, 1'b0);
    // reopen during a frame, four results
    send_request(8'h7e, 1'b1, 1'b1, 1'b1);
    wait_line_idle();
  endtask

  // Extreme control values, then all three equal
  task automatic test_control_values();
    set_pace(PACE_BOTH);
    set_all_regs(8'h00, 8'hff, 8'h80, MAX_LEN_RST);
    send_request(8'h00, 1'b1, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b0, 1'b0);
    send_request(8'h80, 1'b1, 1'b0, 1'b1);
    wait_line_idle();
    set_all_regs(8'h55, 8'h55, 8'h55, MAX_LEN_RST);
    send_request(8'h55, 1'b1, 1'b1, 1'b1);
    wait_line_idle();
  endtask

  // Overflow marker, frame dropping and tiny maximums
  task automatic test_overflow_and_drop();
    set_pace(PACE_BOTH);
    set_all_regs(START_FLAG_RST, STOP_FLAG_RST, ESCAPE_RST, 8'd2);
    send_request(8'h41, 1'b1, 1'b1, 1'b1);
    send_request(8'h7e, 1'b1, 1'b1, 1'b0);
    send_request(8'h33, 1'b1, 1'b0, 1'b0);
    send_request(8'h44, 1'b1, 1'b1, 1'b0);
    send_request(8'h45, 1'b1, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b0, 1'b1);
    send_request(8'h00, 1'b0, 1'b0, 1'b1);
    wait_line_idle();
    write_reg(REG_MAX_LEN, 8'd1);
    send_request(8'h00, 1'b0, 1'b1, 1'b1);
    wait_line_idle();
    write_reg(REG_MAX_LEN, 8'd0);
    send_request(8'h12, 1'b1, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0, 1'b1);
    wait_line_idle();
    write_reg(REG_MAX_LEN, 8'd3);
    send_request(8'h00, 1'b0, 1'b1, 1'b1);
    wait_line_idle();
  endtask

  // Random frames and noise over several register settings and pacing modes
  task automatic test_random_traffic();
    int sent_total;
    int n;
    for (int phase = 0; phase < 8; phase++) begin
      wait_line_idle();
      case (phase)
        0: set_all_regs(START_FLAG_RST, STOP_FLAG_RST, ESCAPE_RST, MAX_LEN_RST);
        1: set_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'd2);
        2: set_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(3, 24)));
        3: set_all_regs(8'h00, 8'hff, 8'h00, 8'hff);
        4: set_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(2, 12)));
        5: begin
          n = $urandom_range(0, 255);
          set_all_regs(8'(n), 8'(n), 8'(n), 8'hff);
        end
        6: set_all_regs(8'hff, 8'h00, 8'hff, 8'($urandom_range(2, 255)));
        default: set_all_regs(8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom_range(4, 16)));
      endcase
      set_pace(pace_e'(phase % 4));
      sent_total = 0;
      while (sent_total < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 15) begin
          send_request(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
          sent_total++;
        end else begin
          send_random_frame(n, $urandom_range(0, 9) == 0);
          sent_total += n;
        end
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_START_FLAG;
    cfg_data_i     = 8'h00;
    in_valid_i     = 1'b0;
    in_byte_i      = 8'h00;
    byte_present_i = 1'b0;
    opens_frame_i  = 1'b0;
    closes_frame_i = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_framing();
    test_control_values();
    test_overflow_and_drop();
    test_random_traffic();
    wait_line_idle();

    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/hbse_pkg.sv
rtl/hbse_front.sv
rtl/hbse_queue.sv
rtl/hbse_back.sv
rtl/hdlc_byte_stuff_encoder_top.sv
rtl/hbse_checker.sv
dv/testbench.sv
